// ----- rtl/core/tpc_pkg.sv -----
// Shared types and constants for the thermostat panel controller.
// Used by tpc_ctrl, tpc_dp and thermostat_panel_controller.
`timescale 1ns / 1ps

package tpc_pkg;

    // Configuration register indexes
    localparam logic C_CFG_STEP  = 1'b0;
    localparam logic C_CFG_LIMIT = 1'b1;

    localparam logic [9:0] C_STEP_RESET  = 10'd50;
    localparam logic [7:0] C_LIMIT_RESET = 8'd45;

    // Button codes
    localparam logic [3:0] C_BTN_START = 4'd1;
    localparam logic [3:0] C_BTN_STOP  = 4'd2;

    localparam logic [9:0]  C_SP_MAX    = 10'd1023;
    // floor(x/5) == (x * 26215) >> 17 for every x below 2**14
    localparam logic [14:0] C_RECIP5    = 15'd26215;
    localparam logic [10:0] C_F_OFFSET  = 11'd32;

    localparam logic [7:0] C_GLYPH_DEG = 8'h63;
    localparam logic [7:0] C_GLYPH_C   = 8'h39;
    localparam logic [7:0] C_GLYPH_F   = 8'h71;

    // Iteration counts: one quotient bit per cycle, one binary bit per cycle
    localparam int C_DIV_STEPS = 15;
    localparam int C_BCD_STEPS = 11;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sat;
        logic mul;
        logic scale;
        logic bcd_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/core/tpc_ctrl.sv -----
// Sequencer for the thermostat panel controller.
// Depends on tpc_pkg; drives the command struct of tpc_dp.
`timescale 1ns / 1ps

module tpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_setup_mode,
    input  tpc_pkg::t_sts i_sts,
    output tpc_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import tpc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SAT   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_BCD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_cnt    = '0;
                    n_state  = i_setup_mode ? S_DIV : S_MUL;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == 4'(C_DIV_STEPS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_cnt     = '0;
                n_state   = S_BCD;
            end
            S_BCD: begin
                cmd.bcd_step = 1'b1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == 4'(C_BCD_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the result register can take the new result
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/tpc_dp.sv -----
// Datapath of the thermostat panel controller: config registers, divider,
// Fahrenheit scaling, binary-to-BCD converter and result register. Uses tpc_pkg.
`timescale 1ns / 1ps

module tpc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tpc_pkg::t_cmd i_cmd,
    output tpc_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [9:0]    i_cfg_wdata,
    input  logic          i_celsius_mode,
    input  logic [3:0]    i_buttons,
    input  logic [15:0]   i_adc_sample,
    input  logic [7:0]    i_measured_temp,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [2:0]    o_leds,
    output logic [31:0]   o_right_display,
    output logic [15:0]   o_left_display
);
    import tpc_pkg::*;

    logic [9:0]  r_step;
    logic [7:0]  r_limit;
    logic [9:0]  r_setpoint;
    logic        r_latch;
    logic        r_out_valid;

    logic        r_cels;
    logic [7:0]  r_temp;
    logic [9:0]  r_shown;
    logic [9:0]  r_rem;
    logic [14:0] r_quo;
    logic [10:0] r_q5;
    logic [10:0] r_bin;
    logic [15:0] r_bcd;
    logic [2:0]  r_leds;
    logic [31:0] r_right;
    logic [15:0] r_left;

    logic [9:0]  divisor;
    logic [10:0] trial;
    logic        ge;
    logic [13:0] x9;
    logic [28:0] prod;
    logic [15:0] bcd_adj;
    logic        heat;

    // zero step counts as one
    assign divisor = (r_step == '0) ? 10'd1 : r_step;
    assign trial   = {r_rem, r_quo[14]};
    assign ge      = (trial >= {1'b0, divisor});

    assign x9   = {1'b0, r_shown, 3'b000} + {4'b0000, r_shown};
    assign prod = {15'b0, x9} * {14'b0, C_RECIP5};

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    assign heat = r_latch && ({2'b00, r_temp} < r_setpoint);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= C_STEP_RESET;
            r_limit     <= C_LIMIT_RESET;
            r_setpoint  <= '0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == C_CFG_STEP) begin
                    r_step <= i_cfg_wdata;
                end else begin
                    r_limit <= i_cfg_wdata[7:0];
                end
            end
            if (i_cmd.load) begin
                if (i_buttons == C_BTN_START) begin
                    r_latch <= 1'b1;
                end else if (i_buttons == C_BTN_STOP) begin
                    r_latch <= 1'b0;
                end
            end
            if (i_cmd.sat) begin
                r_setpoint <= (r_quo > {5'b0, C_SP_MAX}) ? C_SP_MAX : r_quo[9:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cels  <= i_celsius_mode;
            r_temp  <= i_measured_temp;
            r_shown <= {2'b00, i_measured_temp};
            r_rem   <= '0;
            r_quo   <= i_adc_sample[14:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? 10'(trial - {1'b0, divisor}) : trial[9:0];
            r_quo <= {r_quo[13:0], ge};
        end
        if (i_cmd.sat) begin
            r_shown <= (r_quo > {5'b0, C_SP_MAX}) ? C_SP_MAX : r_quo[9:0];
        end
        if (i_cmd.mul) begin
            r_q5 <= prod[27:17];
        end
        if (i_cmd.scale) begin
            r_bin <= r_cels ? {1'b0, r_shown} : r_q5 + C_F_OFFSET;
            r_bcd <= '0;
        end
        if (i_cmd.bcd_step) begin
            r_bcd <= {bcd_adj[14:0], r_bin[10]};
            r_bin <= {r_bin[9:0], 1'b0};
        end
        if (i_cmd.out_load) begin
            r_leds  <= {({2'b00, r_temp} >= {2'b00, r_limit}), r_cels, heat};
            r_right <= {seg_of(r_bcd[7:4]), seg_of(r_bcd[3:0]), C_GLYPH_DEG,
                        r_cels ? C_GLYPH_C : C_GLYPH_F};
            r_left  <= {seg_of(r_bcd[15:12]), seg_of(r_bcd[11:8])};
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_leds          = r_leds;
    assign o_right_display = r_right;
    assign o_left_display  = r_left;

endmodule

// ----- rtl/core/thermostat_panel_controller.sv -----
// Thermostat panel controller: one request in, one display/LED result out.
// Outside setup mode a request runs multiply, scale, 11-step BCD and output;
// setup mode first divides by adc_step bit-serially and saves the setpoint.
// One request at a time; none is taken until the last result is loaded.
// Synchronous active-low reset: adc_step 50, safety_limit 45, setpoint and
// start latch cleared, no result pending.
`timescale 1ns / 1ps

module thermostat_panel_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_setup_mode,
    input  logic        i_celsius_mode,
    input  logic [3:0]  i_buttons,
    input  logic [15:0] i_adc_sample,
    input  logic [7:0]  i_measured_temp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_leds,
    output logic [31:0] o_right_display,
    output logic [15:0] o_left_display
);
    import tpc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_setup_mode (i_setup_mode),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall)
    );

    tpc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_celsius_mode  (i_celsius_mode),
        .i_buttons       (i_buttons),
        .i_adc_sample    (i_adc_sample),
        .i_measured_temp (i_measured_temp),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_leds          (o_leds),
        .o_right_display (o_right_display),
        .o_left_display  (o_left_display)
    );

endmodule
